>>> rtl/tdpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg: shared constants for the trial division prime test
// Default operand width.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

endpackage

>>> rtl/trial_division_prime_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
//
// Drive a signed word on candidate and raise start while busy is low.
// The word is taken at that edge. done is high for exactly one cycle with
// is_prime valid; busy is low in that cycle, so a new start may follow at once.
//
// Negative values, zero, one, two, three and even values raise done at the
// start edge, as done is registered, and busy stays low.
// For an odd value n above three busy rises on the next cycle and the block
// tries odd divisors d = 3, 5, ... while d*d <= n. Each divisor takes
// one bound check of the square in ST_CHECK and then VALUE_WIDTH bits of
// bit-serial restoring division in ST_DIVIDE, one quotient bit per cycle.
// A prime n ends with one more bound check, which finds d*d > n.
// A composite ends on the divide cycle that finds a zero remainder.
// Only one word is in flight at a time.
//
// Reset clears busy and done. The receiver cannot stall: the result is
// shown for one cycle only.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] candidate,
    output logic                          done,
    output logic                          is_prime
);
    import tdpt_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE
    } state_t;

    state_t                 state_reg, state_next;
    logic                   done_reg, done_next;
    logic                   prime_reg, prime_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [VALUE_WIDTH:0]   sq_reg, sq_next;
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [VALUE_WIDTH-1:0] cand_u;
    logic [VALUE_WIDTH-1:0] trial;
    logic [VALUE_WIDTH-1:0] rem_step;

    assign cand_u   = VALUE_WIDTH'(candidate);
    assign trial    = {rem_reg[VALUE_WIDTH-2:0], shift_reg[VALUE_WIDTH-1]};
    assign rem_step = (trial >= d_reg) ? (trial - d_reg) : trial;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next  = cand_u;
                    d_next  = VALUE_WIDTH'(3);
                    sq_next = (VALUE_WIDTH + 1)'(9);
                    if (cand_u[VALUE_WIDTH-1] || cand_u <= VALUE_WIDTH'(1))
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end
                    else if (cand_u <= VALUE_WIDTH'(3))
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b1;
                    end
                    else if (!cand_u[0])
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > {1'b0, n_reg})
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    shift_next = n_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
                rem_next   = rem_step;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    if (rem_step == '0)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // (d + 2)^2 = d^2 + 4d + 4
                        d_next     = d_reg + VALUE_WIDTH'(2);
                        sq_next    = sq_reg + ((VALUE_WIDTH + 1)'(d_reg) << 2)
                                     + (VALUE_WIDTH + 1)'(4);
                        state_next = ST_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_reg <= prime_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign is_prime = prime_reg;

endmodule
